@@ sv/obl_pkg.sv @@
// ----------------------------------------------------------------------------
// obl_pkg
// shared types and constants of the ordered block list
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF  = 8;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_PREPEND     = 3'd1,
    OP_REMOVE_HEAD = 3'd2,
    OP_REMOVE_TAIL = 3'd3,
    OP_REMOVE_BLK  = 3'd4,
    OP_MOVE_END    = 3'd5,
    OP_MOVE_BEGIN  = 3'd6,
    OP_CLEAR       = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_PRESENT   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SHL,
    ACT_SHL_ALL,
    ACT_INS_END,
    ACT_INS_BEGIN
  } act_e;

  typedef struct packed {
    act_e act;
    logic found;
    logic tap_head;
    logic tap_tail;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] block;
  } in_t;

  typedef struct packed {
    logic [7:0] result_block;
    logic [2:0] status;
    logic [4:0] entry_total;
    logic       is_empty;
  } out_t;

endpackage

@@ sv/ordered_block_list.sv @@
// ----------------------------------------------------------------------------
// ordered_block_list
// ordered list of unique cache block indices for replacement order
// ----------------------------------------------------------------------------
//  channel | signals                         | beat
//  in      | in_valid_i in_ready_o in_data_i  | operation, block
//  out     | out_valid_o out_ready_i out_data_o | result_block, status, total, empty
//
//  each beat runs through accept, search of all cells, update of the cell row
//  the update cycle waits while a previous result is still held on out
//  reset clears the count and the fsm; slot contents are not cleared
//  in_ready_o is high only in idle
// ----------------------------------------------------------------------------
module ordered_block_list #(
  parameter int unsigned MAX_ENTRIES = obl_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned INDEX_BITS  = obl_pkg::INDEX_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  obl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output obl_pkg::out_t out_data_o
);

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MaxC = CW'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_e;

  state_e              state_q;
  obl_pkg::in_t        in_q;
  obl_pkg::out_t       out_q, out_d;
  logic                out_valid_q;
  logic [CW-1:0]       occ_q, occ_d;
  logic                fire;
  logic                found;
  logic [IB-1:0]       blk;
  logic [IB-1:0]       tap_or;
  obl_pkg::cell_ctrl_t ctrl;
  obl_pkg::op_e        op;

  logic [IB-1:0]        slot  [MAX_ENTRIES];
  logic [IB-1:0]        tap   [MAX_ENTRIES];
  logic [MAX_ENTRIES:0] after;
  logic [MAX_ENTRIES-1:0] match;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign blk         = IB'(in_q.block);
  assign op          = obl_pkg::op_e'(in_q.operation);
  assign fire        = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  assign found       = after[MAX_ENTRIES];
  assign after[0]    = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [IB-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = slot[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = slot[i+1];
    end
    obl_cell #(
      .IB (IB),
      .CW (CW),
      .IDX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .search_i(state_q == S_SEARCH),
      .ctrl_i  (ctrl),
      .blk_i   (blk),
      .occ_i   (occ_q),
      .left_i  (left_w),
      .right_i (right_w),
      .after_i (after[i]),
      .after_o (after[i+1]),
      .match_o (match[i]),
      .slot_o  (slot[i]),
      .tap_o   (tap[i])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tap_or = tap_or | tap[i];
    end
  end

  always_comb begin
    logic [IB-1:0]    res;
    obl_pkg::status_e st;
    obl_pkg::act_e    act;
    res           = blk;
    st            = obl_pkg::ST_OK;
    act           = obl_pkg::ACT_NONE;
    occ_d         = occ_q;
    ctrl.found    = found;
    ctrl.tap_head = (state_q == S_UPDATE) && (op == obl_pkg::OP_REMOVE_HEAD);
    ctrl.tap_tail = (state_q == S_UPDATE) && (op == obl_pkg::OP_REMOVE_TAIL);
    unique case (op)
      obl_pkg::OP_APPEND, obl_pkg::OP_PREPEND: begin
        if (found) begin
          st = obl_pkg::ST_PRESENT;
        end else if (occ_q >= MaxC) begin
          st = obl_pkg::ST_FULL;
        end else begin
          act   = (op == obl_pkg::OP_APPEND) ? obl_pkg::ACT_INS_END : obl_pkg::ACT_INS_BEGIN;
          occ_d = occ_q + CW'(1);
        end
      end
      obl_pkg::OP_REMOVE_HEAD, obl_pkg::OP_REMOVE_TAIL: begin
        if (occ_q == '0) begin
          st  = obl_pkg::ST_EMPTY;
          res = '0;
        end else begin
          res   = tap_or;
          act   = (op == obl_pkg::OP_REMOVE_HEAD) ? obl_pkg::ACT_SHL_ALL : obl_pkg::ACT_NONE;
          occ_d = occ_q - CW'(1);
        end
      end
      obl_pkg::OP_REMOVE_BLK: begin
        if (found) begin
          act   = obl_pkg::ACT_SHL;
          occ_d = occ_q - CW'(1);
        end else begin
          st = obl_pkg::ST_NOT_FOUND;
        end
      end
      obl_pkg::OP_MOVE_END, obl_pkg::OP_MOVE_BEGIN: begin
        if (!found && (occ_q >= MaxC)) begin
          st = obl_pkg::ST_FULL;
        end else begin
          act   = (op == obl_pkg::OP_MOVE_END) ? obl_pkg::ACT_INS_END : obl_pkg::ACT_INS_BEGIN;
          occ_d = found ? occ_q : occ_q + CW'(1);
        end
      end
      obl_pkg::OP_CLEAR: begin
        res   = '0;
        occ_d = '0;
      end
      default: begin
        res = '0;
      end
    endcase
    ctrl.act           = fire ? act : obl_pkg::ACT_NONE;
    out_d.result_block = 8'(res);
    out_d.status       = st;
    out_d.entry_total  = 5'(occ_d);
    out_d.is_empty     = (occ_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      in_q        <= '0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: state_q <= S_UPDATE;
        S_UPDATE: begin
          if (fire) begin
            occ_q   <= occ_d;
            out_q   <= out_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= MaxC)
    else $error("count above capacity");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("block found in more than one cell");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == obl_pkg::ST_FULL) |-> occ_q == MaxC)
    else $error("full status below capacity");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.is_empty == (occ_q == '0))
    else $error("empty flag disagrees with count");

  a_search_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |=> state_q == S_UPDATE)
    else $error("search not followed by update");
`endif

endmodule

@@ sv/obl_cell.sv @@
// ----------------------------------------------------------------------------
// obl_cell
// one slot of the list: holds a block, matches it, shifts with its neighbors
// ----------------------------------------------------------------------------
module obl_cell #(
  parameter int unsigned IB  = obl_pkg::INDEX_BITS_DEF,
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                search_i,
  input  obl_pkg::cell_ctrl_t ctrl_i,
  input  logic [IB-1:0]       blk_i,
  input  logic [CW-1:0]       occ_i,
  input  logic [IB-1:0]       left_i,
  input  logic [IB-1:0]       right_i,
  input  logic                after_i,
  output logic                after_o,
  output logic                match_o,
  output logic [IB-1:0]       slot_o,
  output logic [IB-1:0]       tap_o
);

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic [IB-1:0] slot_q, slot_d;
  logic          match_q;
  logic          hit;
  logic [CW-1:0] tail_pos;
  logic [CW-1:0] last_pos;

  assign hit      = (IdxC < occ_i) && (slot_q == blk_i);
  assign after_o  = after_i | match_q;
  assign match_o  = match_q;
  assign slot_o   = slot_q;
  assign last_pos = occ_i - CW'(1);
  assign tail_pos = ctrl_i.found ? last_pos : occ_i;

  assign tap_o = ((ctrl_i.tap_head && (IDX == 0)) || (ctrl_i.tap_tail && (IdxC == last_pos)))
                 ? slot_q : '0;

  always_comb begin
    slot_d = slot_q;
    unique case (ctrl_i.act)
      obl_pkg::ACT_NONE: slot_d = slot_q;
      obl_pkg::ACT_SHL: begin
        if (after_o) slot_d = right_i;
      end
      obl_pkg::ACT_SHL_ALL: slot_d = right_i;
      obl_pkg::ACT_INS_END: begin
        if (IdxC == tail_pos) slot_d = blk_i;
        else if (after_o) slot_d = right_i;
      end
      obl_pkg::ACT_INS_BEGIN: begin
        if (!after_i) slot_d = (IDX == 0) ? blk_i : left_i;
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (search_i) begin
      match_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
